// ===== rtl/sit_pkg.sv =====
// shared types for the segment intersection test block
package sit_pkg;

  // per-item decision flags carried alongside the divider chain
  typedef struct packed {
    logic hit;
    logic parallel;
    logic neg_x;
    logic neg_y;
    logic ovf_x;
    logic ovf_y;
  } sit_flags_t;

  localparam int unsigned FLAGS_W = $bits(sit_flags_t);

endpackage

// ===== rtl/sit_if.sv =====
// request and result channel interfaces of the segment intersection test block
interface sit_in_if #(parameter int unsigned W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] a_start_x;
  logic signed [W-1:0] a_start_y;
  logic signed [W-1:0] a_end_x;
  logic signed [W-1:0] a_end_y;
  logic signed [W-1:0] b_start_x;
  logic signed [W-1:0] b_start_y;
  logic signed [W-1:0] b_end_x;
  logic signed [W-1:0] b_end_y;

  modport source (
    output valid, a_start_x, a_start_y, a_end_x, a_end_y,
    output b_start_x, b_start_y, b_end_x, b_end_y,
    input  ready
  );
  modport sink (
    input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
    input  b_start_x, b_start_y, b_end_x, b_end_y,
    output ready
  );
endinterface

interface sit_out_if #(parameter int unsigned W = 16);
  logic                valid;
  logic                ready;
  logic                hit;
  logic                parallel;
  logic signed [W-1:0] meet_x;
  logic signed [W-1:0] meet_y;
  logic                point_clipped;

  modport source (output valid, hit, parallel, meet_x, meet_y, point_clipped, input ready);
  modport sink (input valid, hit, parallel, meet_x, meet_y, point_clipped, output ready);
endinterface

// ===== rtl/sit_front.sv =====
// front pipeline: cross products, hit test and numerator products for the divider chain
module sit_front import sit_pkg::*; #(
  parameter int unsigned W = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic signed [W-1:0]   a_start_x_i,
  input  logic signed [W-1:0]   a_start_y_i,
  input  logic signed [W-1:0]   a_end_x_i,
  input  logic signed [W-1:0]   a_end_y_i,
  input  logic signed [W-1:0]   b_start_x_i,
  input  logic signed [W-1:0]   b_start_y_i,
  input  logic signed [W-1:0]   b_end_x_i,
  input  logic signed [W-1:0]   b_end_y_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [2*W+2:0]        den_o,
  output logic [1:0][2*W+2:0]   rem_o,
  output logic [1:0][W+1:0]     low_o,
  output logic [1:0][W-1:0]     base_o,
  output sit_flags_t            flags_o
);

  localparam int unsigned DW  = W + 1;
  localparam int unsigned PW  = 2 * W + 2;
  localparam int unsigned CW  = 2 * W + 3;
  localparam int unsigned RW  = CW;
  localparam int unsigned QW  = W + 2;
  localparam int unsigned TH  = (CW + 1) / 2;
  localparam int unsigned THH = RW - TH;
  localparam int unsigned PLW = DW + TH;
  localparam int unsigned PHW = DW + THH;
  localparam int unsigned NW  = DW + RW;

  // stage control: a stage moves when empty or when its successor moves
  logic [7:1] v_q;
  logic [8:1] adv;
  logic [7:0] vin;
  logic [7:1] en;

  always_comb begin
    adv[8] = out_ready_i;
    for (int k = 7; k >= 1; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  assign vin = {v_q[6:1], in_valid_i};
  assign en  = adv[7:1] & vin[6:0];
  assign in_ready_o  = adv[1];
  assign out_valid_o = v_q[7];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 1; k <= 7; k++) begin
        if (adv[k]) begin
          v_q[k] <= vin[k-1];
        end
      end
    end
  end

  // stage 1: direction and offset vectors
  logic signed [W-1:0]  s1_px_q, s1_py_q;
  logic signed [DW-1:0] s1_rx_q, s1_ry_q, s1_sx_q, s1_sy_q, s1_dx_q, s1_dy_q;
  // stage 2: products
  logic signed [W-1:0]  s2_px_q, s2_py_q;
  logic signed [DW-1:0] s2_rx_q, s2_ry_q;
  logic signed [PW-1:0] s2_rsy_q, s2_rys_q, s2_dsy_q, s2_dys_q, s2_dry_q, s2_dyr_q;
  // stage 3: cross products
  logic signed [W-1:0]  s3_px_q, s3_py_q;
  logic signed [DW-1:0] s3_rx_q, s3_ry_q;
  logic signed [CW-1:0] s3_den_q, s3_tn_q, s3_un_q;
  // stage 4: magnitudes and decisions
  logic [W-1:0]  s4_px_q, s4_py_q;
  logic [DW-1:0] s4_mrx_q, s4_mry_q;
  logic [RW-1:0] s4_mden_q, s4_mtn_q;
  logic          s4_hit_q, s4_par_q, s4_negx_q, s4_negy_q;
  logic          s4_hit_d, s4_par_d;
  // stage 5: partial products
  logic [W-1:0]   s5_px_q, s5_py_q;
  logic [RW-1:0]  s5_mden_q;
  logic           s5_hit_q, s5_par_q, s5_negx_q, s5_negy_q;
  logic [PLW-1:0] s5_xlo_q, s5_ylo_q;
  logic [PHW-1:0] s5_xhi_q, s5_yhi_q;
  // stage 6: full numerators
  logic [W-1:0]  s6_px_q, s6_py_q;
  logic [RW-1:0] s6_mden_q;
  logic          s6_hit_q, s6_par_q, s6_negx_q, s6_negy_q;
  logic [NW-1:0] s6_nx_q, s6_ny_q;
  // stage 7: divider chain entry
  logic [RW-1:0]        s7_den_q;
  logic [1:0][RW-1:0]   s7_rem_q;
  logic [1:0][QW-1:0]   s7_low_q;
  logic [1:0][W-1:0]    s7_base_q;
  sit_flags_t           s7_flags_q;

  // sign aware range test of both parameters
  always_comb begin
    s4_par_d = (s3_den_q == '0);
    if (s3_den_q[CW-1]) begin
      s4_hit_d = (s3_tn_q <= 0) && (s3_tn_q >= s3_den_q)
              && (s3_un_q <= 0) && (s3_un_q >= s3_den_q);
    end else begin
      s4_hit_d = !s4_par_d && (s3_tn_q >= 0) && (s3_tn_q <= s3_den_q)
              && (s3_un_q >= 0) && (s3_un_q <= s3_den_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_px_q <= a_start_x_i;
      s1_py_q <= a_start_y_i;
      s1_rx_q <= DW'(a_end_x_i) - DW'(a_start_x_i);
      s1_ry_q <= DW'(a_end_y_i) - DW'(a_start_y_i);
      s1_sx_q <= DW'(b_end_x_i) - DW'(b_start_x_i);
      s1_sy_q <= DW'(b_end_y_i) - DW'(b_start_y_i);
      s1_dx_q <= DW'(b_start_x_i) - DW'(a_start_x_i);
      s1_dy_q <= DW'(b_start_y_i) - DW'(a_start_y_i);
    end
    if (en[2]) begin
      s2_px_q  <= s1_px_q;
      s2_py_q  <= s1_py_q;
      s2_rx_q  <= s1_rx_q;
      s2_ry_q  <= s1_ry_q;
      s2_rsy_q <= PW'(s1_rx_q) * PW'(s1_sy_q);
      s2_rys_q <= PW'(s1_ry_q) * PW'(s1_sx_q);
      s2_dsy_q <= PW'(s1_dx_q) * PW'(s1_sy_q);
      s2_dys_q <= PW'(s1_dy_q) * PW'(s1_sx_q);
      s2_dry_q <= PW'(s1_dx_q) * PW'(s1_ry_q);
      s2_dyr_q <= PW'(s1_dy_q) * PW'(s1_rx_q);
    end
    if (en[3]) begin
      s3_px_q  <= s2_px_q;
      s3_py_q  <= s2_py_q;
      s3_rx_q  <= s2_rx_q;
      s3_ry_q  <= s2_ry_q;
      s3_den_q <= CW'(s2_rsy_q) - CW'(s2_rys_q);
      s3_tn_q  <= CW'(s2_dsy_q) - CW'(s2_dys_q);
      s3_un_q  <= CW'(s2_dry_q) - CW'(s2_dyr_q);
    end
    if (en[4]) begin
      s4_px_q   <= s3_px_q;
      s4_py_q   <= s3_py_q;
      s4_mrx_q  <= s3_rx_q[DW-1] ? DW'(~s3_rx_q + 1'b1) : DW'(s3_rx_q);
      s4_mry_q  <= s3_ry_q[DW-1] ? DW'(~s3_ry_q + 1'b1) : DW'(s3_ry_q);
      s4_mden_q <= s3_den_q[CW-1] ? RW'(~s3_den_q + 1'b1) : RW'(s3_den_q);
      s4_mtn_q  <= s3_tn_q[CW-1] ? RW'(~s3_tn_q + 1'b1) : RW'(s3_tn_q);
      s4_hit_q  <= s4_hit_d;
      s4_par_q  <= s4_par_d;
      s4_negx_q <= s3_rx_q[DW-1] ^ s3_tn_q[CW-1] ^ s3_den_q[CW-1];
      s4_negy_q <= s3_ry_q[DW-1] ^ s3_tn_q[CW-1] ^ s3_den_q[CW-1];
    end
    if (en[5]) begin
      s5_px_q   <= s4_px_q;
      s5_py_q   <= s4_py_q;
      s5_mden_q <= s4_mden_q;
      s5_hit_q  <= s4_hit_q;
      s5_par_q  <= s4_par_q;
      s5_negx_q <= s4_negx_q;
      s5_negy_q <= s4_negy_q;
      s5_xlo_q  <= PLW'(s4_mrx_q) * PLW'(s4_mtn_q[TH-1:0]);
      s5_ylo_q  <= PLW'(s4_mry_q) * PLW'(s4_mtn_q[TH-1:0]);
      s5_xhi_q  <= PHW'(s4_mrx_q) * PHW'(s4_mtn_q[RW-1:TH]);
      s5_yhi_q  <= PHW'(s4_mry_q) * PHW'(s4_mtn_q[RW-1:TH]);
    end
    if (en[6]) begin
      s6_px_q   <= s5_px_q;
      s6_py_q   <= s5_py_q;
      s6_mden_q <= s5_mden_q;
      s6_hit_q  <= s5_hit_q;
      s6_par_q  <= s5_par_q;
      s6_negx_q <= s5_negx_q;
      s6_negy_q <= s5_negy_q;
      s6_nx_q   <= (NW'(s5_xhi_q) << TH) + NW'(s5_xlo_q);
      s6_ny_q   <= (NW'(s5_yhi_q) << TH) + NW'(s5_ylo_q);
    end
    if (en[7]) begin
      s7_den_q          <= s6_mden_q;
      s7_rem_q[0]       <= RW'(s6_nx_q[NW-1:QW]);
      s7_rem_q[1]       <= RW'(s6_ny_q[NW-1:QW]);
      s7_low_q[0]       <= s6_nx_q[QW-1:0];
      s7_low_q[1]       <= s6_ny_q[QW-1:0];
      s7_base_q[0]      <= s6_px_q;
      s7_base_q[1]      <= s6_py_q;
      s7_flags_q.hit      <= s6_hit_q;
      s7_flags_q.parallel <= s6_par_q;
      s7_flags_q.neg_x    <= s6_negx_q;
      s7_flags_q.neg_y    <= s6_negy_q;
      // quotient needs more bits than the chain resolves: the point saturates
      s7_flags_q.ovf_x    <= RW'(s6_nx_q[NW-1:QW]) >= s6_mden_q;
      s7_flags_q.ovf_y    <= RW'(s6_ny_q[NW-1:QW]) >= s6_mden_q;
    end
  end

  assign den_o   = s7_den_q;
  assign rem_o   = s7_rem_q;
  assign low_o   = s7_low_q;
  assign base_o  = s7_base_q;
  assign flags_o = s7_flags_q;

endmodule

// ===== rtl/sit_cell.sv =====
// one restoring divider cell: resolves one quotient bit for both coordinates
module sit_cell #(
  parameter int unsigned RW = 35,
  parameter int unsigned QW = 18,
  parameter int unsigned SW = 38
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [RW-1:0]       den_i,
  input  logic [1:0][RW-1:0]  rem_i,
  input  logic [1:0][QW-1:0]  low_i,
  input  logic [SW-1:0]       side_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [RW-1:0]       den_o,
  output logic [1:0][RW-1:0]  rem_o,
  output logic [1:0][QW-1:0]  low_o,
  output logic [SW-1:0]       side_o
);

  logic               valid_q;
  logic [RW-1:0]      den_q;
  logic [1:0][RW-1:0] rem_q, rem_d;
  logic [1:0][QW-1:0] low_q, low_d;
  logic [SW-1:0]      side_q;

  always_comb begin
    logic [RW:0] sh;
    logic        ge;
    for (int l = 0; l < 2; l++) begin
      sh       = {rem_i[l], low_i[l][QW-1]};
      ge       = sh >= {1'b0, den_i};
      rem_d[l] = ge ? RW'(sh - {1'b0, den_i}) : sh[RW-1:0];
      low_d[l] = {low_i[l][QW-2:0], ge};
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      den_q  <= den_i;
      rem_q  <= rem_d;
      low_q  <= low_d;
      side_q <= side_i;
    end
  end

  assign out_valid_o = valid_q;
  assign den_o       = den_q;
  assign rem_o       = rem_q;
  assign low_o       = low_q;
  assign side_o      = side_q;

endmodule

// ===== rtl/segment_intersection_test_core.sv =====
// top level of the 2d segment intersection test block
//
// usage: one request carries two segments (start and end points, signed
// fixed point); one result carries hit, parallel, the crossing point of the
// two carrying lines (truncated toward zero, saturated) and a clip flag.
// both channels are valid/ready; a request or result moves when both are high.
// request to result: seven front stages (vector differences, 17x17 products,
// cross products, magnitudes, split numerator products, numerator sum,
// divider chain entry), then one divider cell per quotient bit (COORD_WIDTH
// + 2 cells), then the output register. throughput: one request per cycle
// unless stalled; every stage and cell is a register slice. when the receiver
// stalls, the result holds in the output register and the pipeline keeps
// filling bubbles; request ready drops only when every stage holds an item.
// reset empties every stage; no result is pending after it.
// parallel or degenerate segments give hit 0, parallel 1 and point 0.
module segment_intersection_test_core import sit_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sit_in_if.sink    req_i,
  sit_out_if.source res_o
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned RW = 2 * W + 3;
  localparam int unsigned QW = W + 2;
  localparam int unsigned SW = 2 * W + FLAGS_W;
  localparam int unsigned EW = W + 4;
  localparam logic signed [EW-1:0] CMAX = EW'((2 ** (W - 1)) - 1);
  localparam logic signed [EW-1:0] CMIN = -CMAX - EW'(1);

  // divider chain links, index 0 is the front output
  logic                 ch_valid [QW+1];
  logic                 ch_ready [QW+1];
  logic [RW-1:0]        ch_den   [QW+1];
  logic [1:0][RW-1:0]   ch_rem   [QW+1];
  logic [1:0][QW-1:0]   ch_low   [QW+1];
  logic [SW-1:0]        ch_side  [QW+1];

  logic [1:0][W-1:0]    front_base;
  sit_flags_t           front_flags;

  sit_front #(.W(W)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .a_start_x_i (req_i.a_start_x),
    .a_start_y_i (req_i.a_start_y),
    .a_end_x_i   (req_i.a_end_x),
    .a_end_y_i   (req_i.a_end_y),
    .b_start_x_i (req_i.b_start_x),
    .b_start_y_i (req_i.b_start_y),
    .b_end_x_i   (req_i.b_end_x),
    .b_end_y_i   (req_i.b_end_y),
    .out_valid_o (ch_valid[0]),
    .out_ready_i (ch_ready[0]),
    .den_o       (ch_den[0]),
    .rem_o       (ch_rem[0]),
    .low_o       (ch_low[0]),
    .base_o      (front_base),
    .flags_o     (front_flags)
  );

  assign ch_side[0] = {front_base, front_flags};

  // one cell per quotient bit, most significant first
  for (genvar g = 0; g < QW; g++) begin : g_cell
    sit_cell #(.RW(RW), .QW(QW), .SW(SW)) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (ch_valid[g]),
      .in_ready_o  (ch_ready[g]),
      .den_i       (ch_den[g]),
      .rem_i       (ch_rem[g]),
      .low_i       (ch_low[g]),
      .side_i      (ch_side[g]),
      .out_valid_o (ch_valid[g+1]),
      .out_ready_i (ch_ready[g+1]),
      .den_o       (ch_den[g+1]),
      .rem_o       (ch_rem[g+1]),
      .low_o       (ch_low[g+1]),
      .side_o      (ch_side[g+1])
    );
  end

  // chain tail: quotient in low, remainder in rem
  logic [1:0][W-1:0] tail_base;
  sit_flags_t        tail_flags;
  logic [1:0]        tail_neg, tail_ovf, lane_clip;
  logic [1:0][W-1:0] lane_val;
  logic              tail_fire;

  assign {tail_base, tail_flags} = ch_side[QW];
  assign tail_neg = {tail_flags.neg_y, tail_flags.neg_x};
  assign tail_ovf = {tail_flags.ovf_y, tail_flags.ovf_x};

  // base plus or minus the floor quotient, pulled toward zero on a remainder
  always_comb begin
    logic signed [EW-1:0] s;
    logic                 rnz;
    for (int l = 0; l < 2; l++) begin
      rnz = |ch_rem[QW][l];
      if (tail_neg[l]) begin
        s = EW'($signed(tail_base[l])) - $signed(EW'(ch_low[QW][l]));
        if (s > 0 && rnz) begin
          s = s - EW'(1);
        end
      end else begin
        s = EW'($signed(tail_base[l])) + $signed(EW'(ch_low[QW][l]));
        if (s < 0 && rnz) begin
          s = s + EW'(1);
        end
      end
      if (tail_ovf[l]) begin
        s = tail_neg[l] ? CMIN : CMAX;
        lane_clip[l] = 1'b1;
      end else if (s > CMAX) begin
        s = CMAX;
        lane_clip[l] = 1'b1;
      end else if (s < CMIN) begin
        s = CMIN;
        lane_clip[l] = 1'b1;
      end else begin
        lane_clip[l] = 1'b0;
      end
      lane_val[l] = s[W-1:0];
    end
  end

  // output register
  logic              res_valid_q;
  logic              res_hit_q, res_par_q, res_clip_q;
  logic [W-1:0]      res_x_q, res_y_q;

  assign ch_ready[QW] = !res_valid_q || res_o.ready;
  assign tail_fire    = ch_ready[QW] && ch_valid[QW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (ch_ready[QW]) begin
      res_valid_q <= ch_valid[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tail_fire) begin
      res_hit_q <= tail_flags.hit;
      res_par_q <= tail_flags.parallel;
      if (tail_flags.parallel) begin
        res_x_q    <= '0;
        res_y_q    <= '0;
        res_clip_q <= 1'b0;
      end else begin
        res_x_q    <= lane_val[0];
        res_y_q    <= lane_val[1];
        res_clip_q <= |lane_clip;
      end
    end
  end

  assign res_o.valid         = res_valid_q;
  assign res_o.hit           = res_hit_q;
  assign res_o.parallel      = res_par_q;
  assign res_o.meet_x        = res_x_q;
  assign res_o.meet_y        = res_y_q;
  assign res_o.point_clipped = res_clip_q;

`ifndef SYNTHESIS
  // a crossing on segment a lies between its in-range end points
  a_hit_not_clipped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.hit |-> !res_o.point_clipped)
    else $error("hit result with saturated point");

  a_parallel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.parallel |->
      !res_o.hit && res_o.meet_x == '0 && res_o.meet_y == '0 && !res_o.point_clipped)
    else $error("parallel result with nonzero payload");

  // a result taken from the chain tail lands in the output register
  a_tail_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_fire |=> res_o.valid)
    else $error("chain tail item lost");
`endif

endmodule

// ===== tb/tb_segment_intersection_test_core.sv =====
// testbench for the segment intersection test core: random and directed segment pairs, scoreboard
`timescale 1ns / 100ps

module tb_segment_intersection_test_core;
  import sit_pkg::*;

  localparam int unsigned CW = 16;
  localparam longint CMAX = 32767;
  localparam longint CMIN = -32768;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int N_RANDOM = 1500;
  localparam int N_CALM = 200;

  // one request: two segments
  typedef struct packed {
    logic [CW-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
  } seg_pair_t;

  // one result
  typedef struct packed {
    logic          hit;
    logic          parallel;
    logic [CW-1:0] mx;
    logic [CW-1:0] my;
    logic          clipped;
  } crossing_t;

  typedef enum int {
    PAIR_WIDE, PAIR_NEAR, PAIR_PARALLEL, PAIR_SHARED, PAIR_FAR
  } pair_kind_e;

  function automatic longint sx(logic [CW-1:0] v);
    return longint'($signed(v));
  endfunction

  // truncated line-crossing coordinate base + dir * tn / den, saturated
  function automatic longint meet_coord(longint base, longint dir, longint tn,
                                        longint den, ref bit clip);
    longint prod, mp, md, q, r, w;
    bit neg;
    prod = dir * tn;
    neg  = (prod < 0) != (den < 0);
    mp   = prod < 0 ? -prod : prod;
    md   = den < 0 ? -den : den;
    q    = mp / md;
    r    = mp % md;
    if (!neg) begin
      w = base + q;
      if (w < 0 && r != 0) w += 1;
    end else begin
      w = base - q;
      if (w > 0 && r != 0) w -= 1;
    end
    if (w > CMAX) begin clip = 1; w = CMAX; end
    if (w < CMIN) begin clip = 1; w = CMIN; end
    return w;
  endfunction

  function automatic crossing_t predict_crossing(seg_pair_t p);
    longint px, py, rx, ry, qx, qy, vx, vy, dx, dy, den, tn, un;
    bit clip;
    crossing_t c;
    px = sx(p.ax0); py = sx(p.ay0);
    rx = sx(p.ax1) - px; ry = sx(p.ay1) - py;
    qx = sx(p.bx0); qy = sx(p.by0);
    vx = sx(p.bx1) - qx; vy = sx(p.by1) - qy;
    dx = qx - px; dy = qy - py;
    den = rx * vy - ry * vx;
    tn  = dx * vy - dy * vx;
    un  = dx * ry - dy * rx;
    c = '0;
    clip = 0;
    if (den == 0) begin
      c.parallel = 1'b1;
      return c;
    end
    if (den > 0) c.hit = tn >= 0 && tn <= den && un >= 0 && un <= den;
    else         c.hit = tn <= 0 && tn >= den && un <= 0 && un >= den;
    c.mx = CW'(meet_coord(px, rx, tn, den, clip));
    c.my = CW'(meet_coord(py, ry, tn, den, clip));
    c.clipped = clip;
    return c;
  endfunction

  // expected crossings in request order
  class crossing_board;
    crossing_t pending[$];
    int errors, checked, hits, parallels, clips;

    function int outstanding();
      return pending.size();
    endfunction

    function void note_request(seg_pair_t p);
      pending.push_back(predict_crossing(p));
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch #%0d at %0t: %s got %0d expected %0d",
               checked, $time, what, got, want);
      errors++;
    endtask

    task check_result(crossing_t got);
      crossing_t want;
      if (pending.size() == 0) begin
        report("unexpected result, valid", 1, 0);
        return;
      end
      want = pending.pop_front();
      if (got.hit !== want.hit) report("hit", got.hit, want.hit);
      if (got.parallel !== want.parallel) report("parallel", got.parallel, want.parallel);
      if (got.mx !== want.mx) report("meet_x", sx(got.mx), sx(want.mx));
      if (got.my !== want.my) report("meet_y", sx(got.my), sx(want.my));
      if (got.clipped !== want.clipped) report("point_clipped", got.clipped, want.clipped);
      hits += want.hit;
      parallels += want.parallel;
      clips += want.clipped;
      checked++;
    endtask
  endclass

  logic clk;
  logic rst_n;
  bit   calm;       // no idling in the final stretch
  int   idle_cycles;
  crossing_board board;

  sit_in_if  #(CW) req ();
  sit_out_if #(CW) res ();

  segment_intersection_test_core #(.COORD_WIDTH(CW)) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req),
    .res_o (res)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // drives every request coordinate at once
  task automatic drive_pair(seg_pair_t p);
    req.a_start_x = p.ax0; req.a_start_y = p.ay0;
    req.a_end_x   = p.ax1; req.a_end_y   = p.ay1;
    req.b_start_x = p.bx0; req.b_start_y = p.by0;
    req.b_end_x   = p.bx1; req.b_end_y   = p.by1;
  endtask

  // presents one request after an optional gap and waits for it to be taken
  task automatic send_request(seg_pair_t p);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 18);
    if (gap > 0) begin
      @(negedge clk);
      req.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req.valid = 1'b1;
    drive_pair(p);
    do @(posedge clk); while (!req.ready);
  endtask

  function automatic logic [CW-1:0] near_val(int span);
    return CW'($urandom_range(0, 2 * span) - span);
  endfunction

  function automatic seg_pair_t make_pair(pair_kind_e kind);
    seg_pair_t p;
    logic [CW-1:0] ox, oy;
    p = seg_pair_t'({$urandom, $urandom, $urandom, $urandom});
    case (kind)
      PAIR_NEAR: begin
        p.ax0 = near_val(400); p.ay0 = near_val(400);
        p.ax1 = near_val(400); p.ay1 = near_val(400);
        p.bx0 = near_val(400); p.by0 = near_val(400);
        p.bx1 = near_val(400); p.by1 = near_val(400);
      end
      PAIR_PARALLEL: begin
        // b is a translated copy of a, sometimes collinear
        ox = near_val(300);
        oy = $urandom_range(0, 1) ? ox : near_val(300);
        p.ax1 = p.ax0 + near_val(500); p.ay1 = p.ay0 + near_val(500);
        p.bx0 = p.ax0 + ox; p.by0 = p.ay0 + oy;
        p.bx1 = p.ax1 + ox; p.by1 = p.ay1 + oy;
      end
      PAIR_SHARED: begin
        // touching at an endpoint, t or u exactly at its bound
        p.ax0 = near_val(2000); p.ay0 = near_val(2000);
        p.ax1 = near_val(2000); p.ay1 = near_val(2000);
        p.bx0 = $urandom_range(0, 1) ? p.ax1 : p.ax0;
        p.by0 = p.bx0 == p.ax1 ? p.ay1 : p.ay0;
        p.bx1 = near_val(2000); p.by1 = near_val(2000);
      end
      PAIR_FAR: begin
        // nearly parallel lines meet far away and saturate
        p.ax0 = near_val(100); p.ay0 = near_val(100);
        p.ax1 = p.ax0 + 16'sd3000; p.ay1 = p.ay0 + CW'($urandom_range(0, 3));
        p.bx0 = near_val(100); p.by0 = near_val(100);
        p.bx1 = p.bx0 + 16'sd3000; p.by1 = p.by0 + CW'($urandom_range(0, 3));
      end
      default: ;
    endcase
    return p;
  endfunction

  // accepted requests feed the scoreboard; watchdog counts quiet cycles
  always @(posedge clk) begin
    if (rst_n) begin
      if (req.valid && req.ready) board.note_request(seg_pair_t'({req.a_start_x,
          req.a_start_y, req.a_end_x, req.a_end_y, req.b_start_x, req.b_start_y,
          req.b_end_x, req.b_end_y}));
      if (res.valid && res.ready) board.check_result(crossing_t'({res.hit,
          res.parallel, res.meet_x, res.meet_y, res.point_clipped}));
      if ((req.valid && req.ready) || (res.valid && res.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", board.outstanding());
        $display("FAILURE");
        $finish;
      end
    end
  end

  // result ready with random stall bursts
  initial begin
    int stall;
    res.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 6) == 0) begin
        stall = $urandom_range(1, 18);
        res.ready = 1'b0;
        repeat (stall - 1) @(negedge clk);
        @(negedge clk);
      end
      res.ready = 1'b1;
    end
  end

  initial begin
    seg_pair_t p;
    seg_pair_t directed[$];
    int tail;
    board = new();
    idle_cycles = 0;
    calm = 0;
    req.valid = 1'b0;
    drive_pair('0);
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // plain crossing at the middle of both segments
    directed.push_back({16'sd0, 16'sd0, 16'sd320, 16'sd320, 16'sd0, 16'sd320, 16'sd320, 16'sd0});
    // lines cross outside both segments
    directed.push_back({16'sd0, 16'sd0, 16'sd16, 16'sd16, 16'sd160, 16'sd0, 16'sd176, -16'sd16});
    // parallel, disjoint
    directed.push_back({16'sd0, 16'sd0, 16'sd100, 16'sd50, 16'sd0, 16'sd10, 16'sd100, 16'sd60});
    // collinear overlapping
    directed.push_back({16'sd0, 16'sd0, 16'sd100, 16'sd100, 16'sd50, 16'sd50, 16'sd150, 16'sd150});
    // zero length segment a, then b
    directed.push_back({16'sd7, 16'sd7, 16'sd7, 16'sd7, 16'sd0, 16'sd0, 16'sd20, 16'sd30});
    directed.push_back({16'sd0, 16'sd0, 16'sd20, 16'sd30, -16'sd5, 16'sd9, -16'sd5, 16'sd9});
    // endpoint touch: t = 0 and t = 1
    directed.push_back({16'sd0, 16'sd0, 16'sd64, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd64});
    directed.push_back({16'sd0, 16'sd0, 16'sd64, 16'sd0, 16'sd64, -16'sd64, 16'sd64, 16'sd64});
    // t-junction, u = 1
    directed.push_back({-16'sd32, 16'sd0, 16'sd32, 16'sd0, 16'sd0, 16'sd32, 16'sd0, 16'sd0});
    // inexact crossing, truncation toward zero on negative coordinates
    directed.push_back({-16'sd10, -16'sd3, -16'sd1, -16'sd7, -16'sd9, -16'sd8, -16'sd2, -16'sd1});
    // full scale diagonals
    directed.push_back({16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff,
                        16'h7fff, 16'h8000});
    // all at the extremes, degenerate
    directed.push_back({16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff,
                        16'h7fff, 16'h7fff});
    // far crossing, positive and negative saturation
    directed.push_back({16'sd0, 16'sd0, 16'sd32000, 16'sd1, 16'sd0, 16'sd10, 16'sd32000, 16'sd10});
    directed.push_back({16'sd0, 16'sd0, -16'sd32000, -16'sd1, 16'sd0, -16'sd10, -16'sd32000,
                        -16'sd10});
    // extreme-length segments nearly parallel
    directed.push_back({16'h8000, 16'h8000, 16'h7fff, 16'h7ffe, 16'h8000, 16'h8001,
                        16'h7fff, 16'h7fff});
    // all zero
    directed.push_back('0);
    foreach (directed[i]) send_request(directed[i]);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 2) begin
        // drain the pipeline completely before carrying on
        @(negedge clk);
        req.valid = 1'b0;
        while (board.outstanding() != 0) @(negedge clk);
      end
      if (n == N_RANDOM - N_CALM) calm = 1;
      case ($urandom_range(0, 9))
        0, 1:    p = make_pair(PAIR_WIDE);
        2, 3, 4: p = make_pair(PAIR_NEAR);
        5:       p = make_pair(PAIR_PARALLEL);
        6, 7:    p = make_pair(PAIR_SHARED);
        default: p = make_pair(PAIR_FAR);
      endcase
      send_request(p);
    end
    @(negedge clk);
    req.valid = 1'b0;

    while (board.outstanding() != 0) @(posedge clk);
    // latency margin for any stray result
    tail = 0;
    while (tail < 3 * (CW + 10)) begin
      @(posedge clk);
      tail++;
    end

    $display("checked %0d crossings: %0d hits, %0d parallel or degenerate, %0d saturated",
             board.checked, board.hits, board.parallels, board.clips);
    $display("mixed wide, near, parallel, endpoint-touching and far-crossing pairs");
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
